@@ hdl/slx_pkg.sv @@
package slx_pkg;

  localparam int POS_BITS_DEF  = 24;
  localparam int LINE_BITS_DEF = 20;
  localparam int KEYWORD_MAX   = 8;
  localparam int KW_BITS       = 8 * KEYWORD_MAX;
  localparam int KW_COUNT      = 20;

  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_IDENT  = 4'd1;
  localparam logic [3:0] M_NUM    = 4'd2;
  localparam logic [3:0] M_NUMDOT = 4'd3;
  localparam logic [3:0] M_FRAC   = 4'd4;
  localparam logic [3:0] M_STR    = 4'd5;
  localparam logic [3:0] M_ESC    = 4'd6;
  localparam logic [3:0] M_CMT    = 4'd7;
  localparam logic [3:0] M_OP     = 4'd8;

  localparam logic [3:0] H_NONE     = 4'd0;
  localparam logic [3:0] H_DOT      = 4'd1;
  localparam logic [3:0] H_DOTDOT   = 4'd2;
  localparam logic [3:0] H_PLUS     = 4'd3;
  localparam logic [3:0] H_MINUS    = 4'd4;
  localparam logic [3:0] H_STAR     = 4'd5;
  localparam logic [3:0] H_STARSTAR = 4'd6;
  localparam logic [3:0] H_SLASH    = 4'd7;
  localparam logic [3:0] H_PERCENT  = 4'd8;
  localparam logic [3:0] H_AMP      = 4'd9;
  localparam logic [3:0] H_PIPE     = 4'd10;
  localparam logic [3:0] H_BANG     = 4'd11;
  localparam logic [3:0] H_EQUAL    = 4'd12;
  localparam logic [3:0] H_GREATER  = 4'd13;
  localparam logic [3:0] H_LESS     = 4'd14;

  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_ERROR  = 6'd1;
  localparam logic [5:0] K_IDENT  = 6'd2;
  localparam logic [5:0] K_NUMBER = 6'd3;
  localparam logic [5:0] K_TEXT   = 6'd4;
  localparam logic [5:0] K_KW0    = 6'd5;
  localparam logic [5:0] K_DOT    = 6'd33;
  localparam logic [5:0] K_DOTDOT = 6'd34;
  localparam logic [5:0] K_RANGEQ = 6'd35;
  localparam logic [5:0] K_ANDAND = 6'd49;
  localparam logic [5:0] K_OROR   = 6'd50;
  localparam logic [5:0] K_ARROW  = 6'd55;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_UNEXPECT = 3'd1;
  localparam logic [2:0] E_UNCLOSED = 3'd2;
  localparam logic [2:0] E_ESCAPE   = 3'd3;
  localparam logic [2:0] E_AMP      = 3'd4;
  localparam logic [2:0] E_BAR      = 3'd5;

  localparam logic [7:0] BOM0 = 8'hEF;
  localparam logic [7:0] BOM1 = 8'hBB;
  localparam logic [7:0] BOM2 = 8'hBF;

  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    "global", "var", "break", "case", "continue", "while", "false", "for",
    "func", "loop", "if", "else", "enum", "match", "static", "struct",
    "self", "true", "nil", "return"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd6, 4'd3, 4'd5, 4'd4, 4'd8, 4'd5, 4'd5, 4'd3,
    4'd4, 4'd4, 4'd2, 4'd4, 4'd4, 4'd5, 4'd6, 4'd6,
    4'd4, 4'd4, 4'd3, 4'd6
  };

  typedef struct packed {
    logic       load;
    logic [1:0] cnt;
  } run_load_t;

  typedef struct packed {
    logic       take;
    logic       emit;
    logic [5:0] kind;
    logic [2:0] err;
    logic [1:0] len;
    logic [3:0] held;
    logic       keep_op;
    logic       to_cmt;
  } op_res_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] word_kind(input logic [KW_BITS-1:0] wc,
                                           input logic [3:0] wl);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (wc == KW_TEXT[i] && wl == KW_LEN[i]) begin
        k = K_KW0 + 6'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "(": k = 6'd25;
      ")": k = 6'd26;
      "{": k = 6'd27;
      "}": k = 6'd28;
      "[": k = 6'd29;
      "]": k = 6'd30;
      ";": k = 6'd31;
      ",": k = 6'd32;
      ":": k = 6'd36;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] held_start(input logic [7:0] c);
    logic [3:0] h;
    case (c)
      ".": h = H_DOT;
      "+": h = H_PLUS;
      "-": h = H_MINUS;
      "*": h = H_STAR;
      "/": h = H_SLASH;
      "%": h = H_PERCENT;
      "&": h = H_AMP;
      "|": h = H_PIPE;
      "!": h = H_BANG;
      "=": h = H_EQUAL;
      ">": h = H_GREATER;
      "<": h = H_LESS;
      default: h = H_NONE;
    endcase
    return h;
  endfunction

  // Closes or extends a pending operator given the next character.
  function automatic op_res_t op_step(input logic [3:0] held, input logic [7:0] c);
    op_res_t r;
    logic    pair;
    logic [5:0] plain;
    logic [5:0] with_eq;
    logic [1:0] base;
    r = '0;
    pair = 1'b1;
    plain = 6'd0;
    with_eq = 6'd0;
    base = 2'd1;
    case (held)
      H_DOT: begin
        pair = 1'b0;
        if (c == ".") begin
          r.take = 1'b1; r.held = H_DOTDOT; r.keep_op = 1'b1;
        end else begin
          r.emit = 1'b1; r.kind = K_DOT; r.len = 2'd1;
        end
      end
      H_DOTDOT: begin
        pair = 1'b0;
        r.emit = 1'b1;
        if (c == "=") begin
          r.take = 1'b1; r.kind = K_RANGEQ; r.len = 2'd3;
        end else begin
          r.kind = K_DOTDOT; r.len = 2'd2;
        end
      end
      H_STAR: begin
        if (c == "*") begin
          pair = 1'b0; r.take = 1'b1; r.held = H_STARSTAR; r.keep_op = 1'b1;
        end
        plain = 6'd41; with_eq = 6'd42;
      end
      H_STARSTAR: begin
        plain = 6'd43; with_eq = 6'd44; base = 2'd2;
      end
      H_SLASH: begin
        if (c == "/") begin
          pair = 1'b0; r.take = 1'b1; r.to_cmt = 1'b1;
        end
        plain = 6'd45; with_eq = 6'd46;
      end
      H_AMP: begin
        pair = 1'b0;
        r.emit = 1'b1;
        if (c == "&") begin
          r.take = 1'b1; r.kind = K_ANDAND; r.len = 2'd2;
        end else begin
          r.kind = K_ERROR; r.err = E_AMP;
        end
      end
      H_PIPE: begin
        pair = 1'b0;
        r.emit = 1'b1;
        if (c == "|") begin
          r.take = 1'b1; r.kind = K_OROR; r.len = 2'd2;
        end else begin
          r.kind = K_ERROR; r.err = E_BAR;
        end
      end
      H_EQUAL: begin
        if (c == ">") begin
          pair = 1'b0; r.take = 1'b1; r.emit = 1'b1; r.kind = K_ARROW; r.len = 2'd2;
        end
        plain = 6'd53; with_eq = 6'd54;
      end
      H_PLUS: begin
        plain = 6'd37; with_eq = 6'd38;
      end
      H_MINUS: begin
        plain = 6'd39; with_eq = 6'd40;
      end
      H_PERCENT: begin
        plain = 6'd47; with_eq = 6'd48;
      end
      H_BANG: begin
        plain = 6'd51; with_eq = 6'd52;
      end
      H_GREATER: begin
        plain = 6'd56; with_eq = 6'd57;
      end
      H_LESS: begin
        plain = 6'd58; with_eq = 6'd59;
      end
      default: begin
        pair = 1'b0;
      end
    endcase
    if (pair) begin
      r.emit = 1'b1;
      if (c == "=") begin
        r.take = 1'b1; r.kind = with_eq; r.len = base + 2'd1;
      end else begin
        r.kind = plain; r.len = base;
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/slx_run_buf.sv @@
module slx_run_buf #(
  parameter int W = 77
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slx_pkg::run_load_t   ld,
  input  logic [3*W-1:0]       ld_data,
  output logic                 can_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [W-1:0]         out_data,
  output logic                 out_last
);

  logic [W-1:0] ent_r [3];
  logic [1:0]   cnt_r;
  logic [1:0]   idx_r;
  logic         pop;

  assign out_valid = idx_r != cnt_r;
  assign out_last  = idx_r == (cnt_r - 2'd1);
  assign pop       = out_valid && out_ready;
  assign can_take  = !out_valid || (out_ready && out_last);

  always_comb begin
    case (idx_r)
      2'd0: out_data = ent_r[0];
      2'd1: out_data = ent_r[1];
      default: out_data = ent_r[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      ent_r[0] <= ld_data[W-1:0];
      ent_r[1] <= ld_data[2*W-1:W];
      ent_r[2] <= ld_data[3*W-1:2*W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (ld.load) begin
      cnt_r <= ld.cnt;
      idx_r <= 2'd0;
    end else if (pop) begin
      if (out_last) begin
        cnt_r <= 2'd0;
        idx_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

@@ hdl/script_lexer_unit.sv @@
// Streaming lexer for a small scripting language.
// The input channel takes one source byte per word in in_tdata; in_tuser set
// marks a word that only ends the source. A zero byte also ends the source.
// The output channel gives one token per word: kind, error code, start
// offset, length and line number in out_tdata, and out_tlast marks the last
// token caused by one input word. One input word yields zero to three tokens.
// An input word is scanned in the cycle it is accepted and its tokens are
// visible on the output in the next cycle. The block takes one byte per cycle
// as long as each byte yields at most one token and the receiver is ready;
// a byte that yields two or three tokens holds the input while they drain
// one at a time through the three-entry result buffer. When the receiver
// stalls, in_tready stays low until the last token of the pending group is
// taken. Reset returns the scanner to the idle state at offset zero, line
// one, with the byte order mark check armed again.
module script_lexer_unit #(
  parameter int POS_BITS  = slx_pkg::POS_BITS_DEF,
  parameter int LINE_BITS = slx_pkg::LINE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [7:0] in_tdata,   // char_byte
  input  logic in_tuser,         // end_of_source
  output logic out_tvalid,
  input  logic out_tready,
  // token_kind, error_code, token_begin, token_len, line_number, zero fill
  output logic [((9 + 2*POS_BITS + LINE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic out_tlast         // last_of_run
);

  localparam int RW = 9 + 2*POS_BITS + LINE_BITS;
  localparam int DW = ((RW + 7) / 8) * 8;
  localparam logic [POS_BITS-1:0]  POS_TOP = '1;
  localparam logic [LINE_BITS-1:0] LN_TOP  = '1;
  localparam int KB = slx_pkg::KW_BITS;

  typedef struct packed {
    logic [LINE_BITS-1:0] line;
    logic [POS_BITS-1:0]  len;
    logic [POS_BITS-1:0]  begin_pos;
    logic [2:0]           err;
    logic [5:0]           kind;
  } res_t;

  logic [3:0]           mode_r, mode_nxt;
  logic [1:0]           bom_r, bom_nxt;
  logic [POS_BITS-1:0]  off_r, off_nxt;
  logic [POS_BITS-1:0]  tb_r, tb_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [KB-1:0]        wc_r, wc_nxt;
  logic [3:0]           wl_r, wl_nxt;
  logic                 sq_r, sq_nxt;
  logic [3:0]           held_r, held_nxt;

  logic                 acc;
  logic [7:0]           c;
  logic                 eos;
  logic                 endf;
  logic [7:0]           cc;
  logic [7:0]           bom_byte;
  logic                 bom_hit;
  logic                 replay;
  logic [POS_BITS-1:0]  off_cur;
  logic [POS_BITS-1:0]  dot;
  logic                 rescan;
  logic [5:0]           sk;
  logic [3:0]           hs;
  slx_pkg::op_res_t     opr;
  logic                 v0, v1, v2;
  res_t                 d0, d1, d2;
  res_t                 q0, q1;
  slx_pkg::run_load_t   ld;
  logic                 can_take;
  logic [RW-1:0]        out_word;
  res_t                 out_res;

  function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] p);
    return (p == POS_TOP) ? POS_TOP : p + 1'b1;
  endfunction

  function automatic logic [POS_BITS-1:0] pos_diff(input logic [POS_BITS-1:0] a,
                                                   input logic [POS_BITS-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic res_t mk(input logic [5:0] kind, input logic [2:0] err,
                              input logic [POS_BITS-1:0] bp,
                              input logic [POS_BITS-1:0] len,
                              input logic [LINE_BITS-1:0] ln);
    res_t r;
    r.kind = kind;
    r.err = err;
    r.begin_pos = bp;
    r.len = len;
    r.line = ln;
    return r;
  endfunction

  assign acc  = in_tvalid && in_tready;
  assign c    = in_tdata;
  assign eos  = in_tuser;
  assign endf = eos || (c == 8'd0);
  assign cc   = endf ? 8'd0 : c;
  assign in_tready = can_take;

  always_comb begin
    case (bom_r)
      2'd0: bom_byte = slx_pkg::BOM0;
      2'd1: bom_byte = slx_pkg::BOM1;
      default: bom_byte = slx_pkg::BOM2;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    bom_nxt  = bom_r;
    off_nxt  = off_r;
    tb_nxt   = tb_r;
    line_nxt = line_r;
    wc_nxt   = wc_r;
    wl_nxt   = wl_r;
    sq_nxt   = sq_r;
    held_nxt = held_r;
    v0 = 1'b0; v1 = 1'b0; v2 = 1'b0;
    d0 = '0; d1 = '0; d2 = '0;
    rescan = 1'b0;
    dot = '0;
    sk = 6'd0;
    hs = slx_pkg::H_NONE;
    opr = '0;
    bom_hit = (bom_r != 2'd3) && !endf && (c == bom_byte);
    replay  = (bom_r != 2'd3) && !bom_hit;
    off_cur = replay ? POS_BITS'(bom_r) : off_r;

    if (bom_hit) begin
      bom_nxt = bom_r + 2'd1;
      if (bom_r == 2'd2) begin
        off_nxt = POS_BITS'(3);
      end
    end else begin
      if (replay) begin
        bom_nxt = 2'd3;
        v0 = bom_r != 2'd0;
        d0 = mk(slx_pkg::K_ERROR, slx_pkg::E_UNEXPECT, '0, '0, line_r);
        v1 = bom_r == 2'd2;
        d1 = mk(slx_pkg::K_ERROR, slx_pkg::E_UNEXPECT, POS_BITS'(1), '0, line_r);
      end

      case (mode_r)
        slx_pkg::M_IDENT: begin
          if (!endf && (slx_pkg::is_alpha(c) || slx_pkg::is_digit(c))) begin
            if (wl_r < 4'(slx_pkg::KEYWORD_MAX)) begin
              wc_nxt = {wc_r[KB-9:0], c};
            end
            if (wl_r != 4'd15) begin
              wl_nxt = wl_r + 4'd1;
            end
          end else begin
            v0 = 1'b1;
            d0 = mk(slx_pkg::word_kind(wc_r, wl_r), slx_pkg::E_NONE, tb_r,
                    pos_diff(off_cur, tb_r), line_r);
            rescan = 1'b1;
          end
        end
        slx_pkg::M_NUM: begin
          if (!endf && slx_pkg::is_digit(c)) begin
            mode_nxt = slx_pkg::M_NUM;
          end else if (!endf && c == ".") begin
            mode_nxt = slx_pkg::M_NUMDOT;
          end else begin
            v0 = 1'b1;
            d0 = mk(slx_pkg::K_NUMBER, slx_pkg::E_NONE, tb_r,
                    pos_diff(off_cur, tb_r), line_r);
            rescan = 1'b1;
          end
        end
        slx_pkg::M_NUMDOT: begin
          if (!endf && slx_pkg::is_digit(c)) begin
            mode_nxt = slx_pkg::M_FRAC;
          end else begin
            dot = (off_cur != '0) ? off_cur - 1'b1 : '0;
            v0 = 1'b1;
            d0 = mk(slx_pkg::K_NUMBER, slx_pkg::E_NONE, tb_r,
                    pos_diff(dot, tb_r), line_r);
            tb_nxt = dot;
            if (cc == ".") begin
              held_nxt = slx_pkg::H_DOTDOT;
              mode_nxt = slx_pkg::M_OP;
            end else begin
              v1 = 1'b1;
              d1 = mk(slx_pkg::K_DOT, slx_pkg::E_NONE, dot, POS_BITS'(1), line_r);
              held_nxt = slx_pkg::H_NONE;
              rescan = 1'b1;
            end
          end
        end
        slx_pkg::M_FRAC: begin
          if (endf || !slx_pkg::is_digit(c)) begin
            v0 = 1'b1;
            d0 = mk(slx_pkg::K_NUMBER, slx_pkg::E_NONE, tb_r,
                    pos_diff(off_cur, tb_r), line_r);
            rescan = 1'b1;
          end
        end
        slx_pkg::M_STR: begin
          if (!endf && c == (sq_r ? 8'h27 : 8'h22)) begin
            v0 = 1'b1;
            d0 = mk(slx_pkg::K_TEXT, slx_pkg::E_NONE, tb_r,
                    pos_diff(pos_inc(off_cur), tb_r), line_r);
            mode_nxt = slx_pkg::M_IDLE;
          end else if (endf || c == 8'h0A) begin
            v0 = 1'b1;
            d0 = mk(slx_pkg::K_ERROR, slx_pkg::E_UNCLOSED, tb_r, '0, line_r);
            rescan = 1'b1;
          end else if (c == 8'h5C) begin
            mode_nxt = slx_pkg::M_ESC;
          end
        end
        slx_pkg::M_ESC: begin
          if (!endf && (c == "n" || c == "t" || c == "r" || c == "a" ||
                        c == 8'h22 || c == 8'h27 || c == 8'h5C)) begin
            mode_nxt = slx_pkg::M_STR;
          end else begin
            v0 = 1'b1;
            d0 = mk(slx_pkg::K_ERROR, slx_pkg::E_ESCAPE, tb_r, '0, line_r);
            rescan = 1'b1;
          end
        end
        slx_pkg::M_CMT: begin
          if (endf || c == 8'h0A) begin
            rescan = 1'b1;
          end
        end
        slx_pkg::M_OP: begin
          opr = slx_pkg::op_step(held_r, cc);
          held_nxt = opr.held;
          mode_nxt = opr.keep_op ? slx_pkg::M_OP :
                     (opr.to_cmt ? slx_pkg::M_CMT : slx_pkg::M_IDLE);
          v0 = opr.emit;
          d0 = mk(opr.kind, opr.err, tb_r, POS_BITS'(opr.len), line_r);
          rescan = !opr.take;
        end
        default: begin
          rescan = 1'b1;
        end
      endcase

      if (rescan) begin
        mode_nxt = slx_pkg::M_IDLE;
        sk = slx_pkg::single_op(c);
        hs = slx_pkg::held_start(c);
        if (endf) begin
          v2 = 1'b1;
          d2 = mk(slx_pkg::K_EOF, slx_pkg::E_NONE, off_cur, '0, line_r);
        end else if (c == 8'h0A) begin
          if (line_r != LN_TOP) begin
            line_nxt = line_r + 1'b1;
          end
        end else if (c == " " || c == 8'h0D || c == 8'h09) begin
          mode_nxt = slx_pkg::M_IDLE;
        end else begin
          tb_nxt = off_cur;
          if (slx_pkg::is_alpha(c)) begin
            wc_nxt = KB'(c);
            wl_nxt = 4'd1;
            mode_nxt = slx_pkg::M_IDENT;
          end else if (slx_pkg::is_digit(c)) begin
            mode_nxt = slx_pkg::M_NUM;
          end else if (c == 8'h22 || c == 8'h27) begin
            sq_nxt = c == 8'h27;
            mode_nxt = slx_pkg::M_STR;
          end else if (sk != 6'd0) begin
            v2 = 1'b1;
            d2 = mk(sk, slx_pkg::E_NONE, off_cur, POS_BITS'(1), line_r);
          end else if (hs != slx_pkg::H_NONE) begin
            held_nxt = hs;
            mode_nxt = slx_pkg::M_OP;
          end else begin
            v2 = 1'b1;
            d2 = mk(slx_pkg::K_ERROR, slx_pkg::E_UNEXPECT, off_cur, '0, line_r);
          end
        end
      end

      if (!eos) begin
        off_nxt = pos_inc(off_cur);
      end else begin
        off_nxt = off_cur;
      end
    end
  end

  always_comb begin
    q0 = v0 ? d0 : (v1 ? d1 : d2);
    q1 = (v0 && v1) ? d1 : d2;
    ld.load = acc;
    ld.cnt  = 2'(v0) + 2'(v1) + 2'(v2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= slx_pkg::M_IDLE;
      bom_r  <= 2'd0;
      off_r  <= '0;
      tb_r   <= '0;
      line_r <= LINE_BITS'(1);
      wc_r   <= '0;
      wl_r   <= 4'd0;
      sq_r   <= 1'b0;
      held_r <= slx_pkg::H_NONE;
    end else if (acc) begin
      mode_r <= mode_nxt;
      bom_r  <= bom_nxt;
      off_r  <= off_nxt;
      tb_r   <= tb_nxt;
      line_r <= line_nxt;
      wc_r   <= wc_nxt;
      wl_r   <= wl_nxt;
      sq_r   <= sq_nxt;
      held_r <= held_nxt;
    end
  end

  slx_run_buf #(
    .W(RW)
  ) u_run_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (ld),
    .ld_data  ({d2, q1, q0}),
    .can_take (can_take),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_word),
    .out_last (out_tlast)
  );

  assign out_tdata = DW'(out_word);
  assign out_res   = out_word;

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while a token group is stalled");

  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_res.kind == slx_pkg::K_ERROR) == (out_res.err != slx_pkg::E_NONE)))
    else $error("error code does not match token kind");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res.kind == slx_pkg::K_EOF) |-> out_tlast)
    else $error("end-of-file token is not the last of its group");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_res.line != '0))
    else $error("token carries line zero");

endmodule

@@ dv/tb_script_lexer_unit.sv @@
`timescale 1ns / 1ps

module tb_script_lexer_unit;

  localparam int PB = slx_pkg::POS_BITS_DEF;
  localparam int LB = slx_pkg::LINE_BITS_DEF;
  localparam int DW = ((9 + 2*PB + LB + 7) / 8) * 8;
  localparam logic [PB-1:0] PTOP = '1;
  localparam logic [LB-1:0] LTOP = '1;

  typedef struct packed {
    logic [5:0]    kind;
    logic [2:0]    err;
    logic [PB-1:0] tbeg;
    logic [PB-1:0] tlen;
    logic [LB-1:0] line;
    logic          last;
  } token_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DW-1:0] out_tdata;
  logic out_tlast;

  script_lexer_unit i_dut (.*);

  always #5 clk = ~clk;

  // Scanner state kept by the predictor.
  logic [3:0]    sc_mode;
  logic [1:0]    sc_bom;
  logic [PB-1:0] sc_off;
  logic [PB-1:0] sc_tbeg;
  logic [LB-1:0] sc_line;
  logic [63:0]   sc_word;
  logic [3:0]    sc_wlen;
  logic          sc_single;
  logic [3:0]    sc_held;

  token_t expected_tokens[$];
  token_t run_tokens[$];
  int     fails = 0;
  bit     rx_stall_on = 1'b1;
  bit     tx_gap_on = 1'b1;

  string kw_names[20] = '{"global", "var", "break", "case", "continue", "while", "false",
    "for", "func", "loop", "if", "else", "enum", "match", "static", "struct", "self",
    "true", "nil", "return"};

  function automatic logic [PB-1:0] pinc(logic [PB-1:0] p);
    return p == PTOP ? p : p + 1'b1;
  endfunction

  function automatic logic [PB-1:0] pdiff(logic [PB-1:0] a, logic [PB-1:0] b);
    return a > b ? a - b : '0;
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] classify_word();
    for (int k = 0; k < 20; k++) begin
      string s = kw_names[k];
      bit same = (s.len() == sc_wlen);
      for (int i = 0; i < s.len() && same; i++)
        if (sc_word[8*i +: 8] != s[i]) same = 0;
      if (same) return 6'(5 + k);
    end
    return slx_pkg::K_IDENT;
  endfunction

  task automatic add_token(logic [5:0] k, logic [2:0] e, logic [PB-1:0] b, logic [PB-1:0] l);
    token_t t;
    if (run_tokens.size() >= 3) return;
    t = '{k, e, b, l, sc_line, 1'b0};
    run_tokens.push_back(t);
  endtask

  function automatic logic [5:0] direct_op(logic [7:0] c);
    case (c)
      "(": return 6'd25; ")": return 6'd26; "{": return 6'd27; "}": return 6'd28;
      "[": return 6'd29; "]": return 6'd30; ";": return 6'd31; ",": return 6'd32;
      ":": return 6'd36;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [3:0] pending_op(logic [7:0] c);
    case (c)
      ".": return slx_pkg::H_DOT;
      "+": return slx_pkg::H_PLUS;
      "-": return slx_pkg::H_MINUS;
      "*": return slx_pkg::H_STAR;
      "/": return slx_pkg::H_SLASH;
      "%": return slx_pkg::H_PERCENT;
      "&": return slx_pkg::H_AMP;
      "|": return slx_pkg::H_PIPE;
      "!": return slx_pkg::H_BANG;
      "=": return slx_pkg::H_EQUAL;
      ">": return slx_pkg::H_GREATER;
      "<": return slx_pkg::H_LESS;
      default: return slx_pkg::H_NONE;
    endcase
  endfunction

  task automatic close_operator(logic [7:0] c, output bit took);
    logic [PB-1:0] b;
    logic [5:0] pl, we;
    logic [PB-1:0] base;
    b = sc_tbeg;
    sc_mode = slx_pkg::M_IDLE;
    pl = 6'd0;
    we = 6'd0;
    base = PB'(1);
    took = 0;
    case (sc_held)
      slx_pkg::H_DOT: begin
        if (c == ".") begin
          sc_held = slx_pkg::H_DOTDOT; sc_mode = slx_pkg::M_OP; took = 1; return;
        end
        add_token(slx_pkg::K_DOT, slx_pkg::E_NONE, b, 1); sc_held = slx_pkg::H_NONE; return;
      end
      slx_pkg::H_DOTDOT: begin
        sc_held = slx_pkg::H_NONE;
        if (c == "=") begin
          add_token(slx_pkg::K_RANGEQ, slx_pkg::E_NONE, b, 3); took = 1; return;
        end
        add_token(slx_pkg::K_DOTDOT, slx_pkg::E_NONE, b, 2); return;
      end
      slx_pkg::H_STAR: begin
        if (c == "*") begin
          sc_held = slx_pkg::H_STARSTAR; sc_mode = slx_pkg::M_OP; took = 1; return;
        end
        pl = 6'd41; we = 6'd42;
      end
      slx_pkg::H_STARSTAR: begin pl = 6'd43; we = 6'd44; base = PB'(2); end
      slx_pkg::H_SLASH: begin
        if (c == "/") begin
          sc_held = slx_pkg::H_NONE; sc_mode = slx_pkg::M_CMT; took = 1; return;
        end
        pl = 6'd45; we = 6'd46;
      end
      slx_pkg::H_AMP: begin
        sc_held = slx_pkg::H_NONE;
        if (c == "&") begin
          add_token(slx_pkg::K_ANDAND, slx_pkg::E_NONE, b, 2); took = 1; return;
        end
        add_token(slx_pkg::K_ERROR, slx_pkg::E_AMP, b, 0); return;
      end
      slx_pkg::H_PIPE: begin
        sc_held = slx_pkg::H_NONE;
        if (c == "|") begin
          add_token(slx_pkg::K_OROR, slx_pkg::E_NONE, b, 2); took = 1; return;
        end
        add_token(slx_pkg::K_ERROR, slx_pkg::E_BAR, b, 0); return;
      end
      slx_pkg::H_EQUAL: begin
        if (c == ">") begin
          sc_held = slx_pkg::H_NONE;
          add_token(slx_pkg::K_ARROW, slx_pkg::E_NONE, b, 2);
          took = 1;
          return;
        end
        pl = 6'd53; we = 6'd54;
      end
      slx_pkg::H_PLUS: begin pl = 6'd37; we = 6'd38; end
      slx_pkg::H_MINUS: begin pl = 6'd39; we = 6'd40; end
      slx_pkg::H_PERCENT: begin pl = 6'd47; we = 6'd48; end
      slx_pkg::H_BANG: begin pl = 6'd51; we = 6'd52; end
      slx_pkg::H_GREATER: begin pl = 6'd56; we = 6'd57; end
      slx_pkg::H_LESS: begin pl = 6'd58; we = 6'd59; end
      default: begin sc_held = slx_pkg::H_NONE; return; end
    endcase
    sc_held = slx_pkg::H_NONE;
    if (c == "=") begin add_token(we, slx_pkg::E_NONE, b, base + 1'b1); took = 1; end
    else add_token(pl, slx_pkg::E_NONE, b, base);
  endtask

  task automatic scan_once(logic [7:0] c, bit fin, output bit done);
    logic [PB-1:0] off;
    logic [PB-1:0] dot;
    logic [5:0] k;
    logic [3:0] h;
    off = sc_off;
    done = 1;
    case (sc_mode)
      slx_pkg::M_IDENT: begin
        if (!fin && (alpha_c(c) || digit_c(c))) begin
          if (sc_wlen < 4'(slx_pkg::KEYWORD_MAX)) sc_word[8*sc_wlen +: 8] = c;
          if (sc_wlen < 4'd15) sc_wlen++;
          return;
        end
        add_token(classify_word(), slx_pkg::E_NONE, sc_tbeg, pdiff(off, sc_tbeg));
        sc_mode = slx_pkg::M_IDLE; done = 0; return;
      end
      slx_pkg::M_NUM: begin
        if (!fin && digit_c(c)) return;
        if (!fin && c == ".") begin sc_mode = slx_pkg::M_NUMDOT; return; end
        add_token(slx_pkg::K_NUMBER, slx_pkg::E_NONE, sc_tbeg, pdiff(off, sc_tbeg));
        sc_mode = slx_pkg::M_IDLE; done = 0; return;
      end
      slx_pkg::M_NUMDOT: begin
        if (!fin && digit_c(c)) begin sc_mode = slx_pkg::M_FRAC; return; end
        dot = off > 0 ? off - 1'b1 : '0;
        add_token(slx_pkg::K_NUMBER, slx_pkg::E_NONE, sc_tbeg, pdiff(dot, sc_tbeg));
        sc_tbeg = dot; sc_held = slx_pkg::H_DOT; sc_mode = slx_pkg::M_OP; done = 0; return;
      end
      slx_pkg::M_FRAC: begin
        if (!fin && digit_c(c)) return;
        add_token(slx_pkg::K_NUMBER, slx_pkg::E_NONE, sc_tbeg, pdiff(off, sc_tbeg));
        sc_mode = slx_pkg::M_IDLE; done = 0; return;
      end
      slx_pkg::M_STR: begin
        if (!fin && c == (sc_single ? 8'h27 : 8'h22)) begin
          add_token(slx_pkg::K_TEXT, slx_pkg::E_NONE, sc_tbeg, pdiff(pinc(off), sc_tbeg));
          sc_mode = slx_pkg::M_IDLE; return;
        end
        if (fin || c == 8'h0a) begin
          add_token(slx_pkg::K_ERROR, slx_pkg::E_UNCLOSED, sc_tbeg, 0);
          sc_mode = slx_pkg::M_IDLE; done = 0; return;
        end
        if (c == 8'h5c) sc_mode = slx_pkg::M_ESC;
        return;
      end
      slx_pkg::M_ESC: begin
        if (!fin && (c == "n" || c == "t" || c == "r" || c == "a" || c == 8'h22 ||
                     c == 8'h27 || c == 8'h5c)) begin
          sc_mode = slx_pkg::M_STR; return;
        end
        add_token(slx_pkg::K_ERROR, slx_pkg::E_ESCAPE, sc_tbeg, 0);
        sc_mode = slx_pkg::M_IDLE; done = 0; return;
      end
      slx_pkg::M_CMT: begin
        if (fin || c == 8'h0a) begin sc_mode = slx_pkg::M_IDLE; done = 0; end
        return;
      end
      slx_pkg::M_OP: begin
        close_operator(fin ? 8'h00 : c, done);
        return;
      end
      default: ;
    endcase
    sc_mode = slx_pkg::M_IDLE;
    if (fin) begin add_token(slx_pkg::K_EOF, slx_pkg::E_NONE, off, 0); return; end
    if (c == 8'h0a) begin if (sc_line != LTOP) sc_line++; return; end
    if (c == " " || c == 8'h0d || c == 8'h09) return;
    sc_tbeg = off;
    if (alpha_c(c)) begin
      sc_word = 64'(c); sc_wlen = 4'd1; sc_mode = slx_pkg::M_IDENT; return;
    end
    if (digit_c(c)) begin sc_mode = slx_pkg::M_NUM; return; end
    if (c == 8'h22 || c == 8'h27) begin
      sc_single = (c == 8'h27); sc_mode = slx_pkg::M_STR; return;
    end
    k = direct_op(c);
    if (k != 0) begin add_token(k, slx_pkg::E_NONE, off, 1); return; end
    h = pending_op(c);
    if (h != slx_pkg::H_NONE) begin sc_held = h; sc_mode = slx_pkg::M_OP; return; end
    add_token(slx_pkg::K_ERROR, slx_pkg::E_UNEXPECT, off, 0);
  endtask

  task automatic scan_char(logic [7:0] c, bit fin);
    bit done;
    for (int p = 0; p < 4; p++) begin
      scan_once(c, fin, done);
      if (done) return;
    end
  endtask

  task automatic lexer_reset();
    sc_mode = slx_pkg::M_IDLE; sc_bom = 2'd0; sc_off = '0; sc_tbeg = '0; sc_line = LB'(1);
    sc_word = '0; sc_wlen = 4'd0; sc_single = 1'b0; sc_held = slx_pkg::H_NONE;
  endtask

  task automatic predict_tokens(logic [7:0] c, bit eos);
    logic [7:0] bom[3];
    bit fin;
    int held;
    bom = '{slx_pkg::BOM0, slx_pkg::BOM1, slx_pkg::BOM2};
    fin = eos || c == 0;
    run_tokens.delete();
    if (sc_bom < 3) begin
      if (!fin && c == bom[sc_bom]) begin
        sc_bom++;
        if (sc_bom == 3) sc_off = pinc(pinc(pinc(sc_off)));
        return;
      end
      held = sc_bom;
      sc_bom = 2'd3;
      for (int i = 0; i < held; i++) begin
        scan_char(bom[i], 0);
        sc_off = pinc(sc_off);
      end
    end
    scan_char(c, fin);
    if (!eos) sc_off = pinc(sc_off);
    if (run_tokens.size() > 0) run_tokens[run_tokens.size()-1].last = 1'b1;
    foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
  endtask

  task automatic send_word(logic [7:0] c, bit eos);
    int gap;
    gap = tx_gap_on ? int'($urandom_range(0, 16)) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_tokens(c, eos);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 0);
  endtask

  initial begin
    int wait_n;
    forever begin
      wait_n = rx_stall_on ? int'($urandom_range(0, 16)) : 0;
      @(negedge clk);
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(rst_n && out_tvalid)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    token_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[5:0], out_tdata[8:6], out_tdata[9 +: PB], out_tdata[9+PB +: PB],
              out_tdata[9+2*PB +: LB], out_tlast};
      if (expected_tokens.size() == 0) begin
        $error("token_kind exp none got %0d", got.kind);
        fails++;
      end else begin
        exp = expected_tokens.pop_front();
        if (got.kind != exp.kind) begin
          $error("token_kind exp %0d got %0d", exp.kind, got.kind); fails++;
        end
        if (got.err != exp.err) begin
          $error("error_code exp %0d got %0d", exp.err, got.err); fails++;
        end
        if (got.tbeg != exp.tbeg) begin
          $error("token_begin exp %0d got %0d", exp.tbeg, got.tbeg); fails++;
        end
        if (got.tlen != exp.tlen) begin
          $error("token_len exp %0d got %0d", exp.tlen, got.tlen); fails++;
        end
        if (got.line != exp.line) begin
          $error("line_number exp %0d got %0d", exp.line, got.line); fails++;
        end
        if (got.last != exp.last) begin
          $error("last_of_run exp %0d got %0d", exp.last, got.last); fails++;
        end
      end
    end
  end

  task automatic test_bom_and_partial();
    send_word(slx_pkg::BOM0, 0); send_word(slx_pkg::BOM1, 0); send_word(slx_pkg::BOM2, 0);
    send_text("a");
    send_word(8'h00, 0);
    send_word(slx_pkg::BOM0, 0); send_word(slx_pkg::BOM1, 0); send_text("z");
  endtask

  task automatic test_keywords();
    send_text("while x1 returns continue9 abcdefghij if ");
    send_word(8'h00, 1);
  endtask

  task automatic test_numbers_strings();
    send_text("12.5 7.. 3.x \"a\\n\" 'q\\z' \"open\n");
    send_word(8'hff, 0);
    send_word(8'h00, 1);
  endtask

  task automatic test_operators();
    send_text("..= ** **= => & | && || != <= >= %= /= -= += //c\n");
    send_text("@;");
    send_word(8'h80, 0);
    send_word(8'h00, 0);
  endtask

  task automatic test_random();
    string frags[] = '{"var", "while", "x_9", "12", "3.75", "4.", "\"s\\t\"", "'u'",
      "\"bad\\q\"", "\"nl\n", "..", "..=", "**=", "=>", "&&", "||", "&x", "|y", "//c\n",
      "+=", "-", "<", ">=", "!", "(", "}", ";", ",", ":", "%", "/", "\n", " ", "\t",
      "\r", "struct", "nil", "abcdefghijkl", "#", "$"};
    int n = 0;
    while (n < 270) begin
      if ($urandom_range(0, 9) < 7) begin
        string f = frags[$urandom_range(0, frags.size()-1)];
        send_text(f);
        n += f.len();
      end else begin
        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        n++;
      end
      if ($urandom_range(0, 30) == 0) begin
        tx_gap_on = !tx_gap_on;
        rx_stall_on = !rx_stall_on;
      end
    end
    send_word(8'h00, 1);
  endtask

  initial begin
    lexer_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_bom_and_partial();
    test_keywords();
    test_numbers_strings();
    test_operators();
    test_random();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("[script_lexer_unit] OK");
    else $display("[script_lexer_unit] ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("[script_lexer_unit] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/slx_pkg.sv
hdl/slx_run_buf.sv
hdl/script_lexer_unit.sv
dv/tb_script_lexer_unit.sv
